// ===== src/tra_pkg.sv =====
// Shared types and constants of the transverse region accumulator.
// Holds the payload structs, the internal snapshot types and the field codes.
// Depends on nothing.
package tra_pkg;

  localparam int PHI_BITS   = 16;
  localparam int PT_BITS    = 20;
  localparam int COUNT_BITS = 12;
  localparam int SUM_BITS   = 32;

  localparam logic ACT_HEADER   = 1'b0;
  localparam logic ACT_PARTICLE = 1'b1;

  localparam logic REF_JET   = 1'b0;
  localparam logic REF_TRACK = 1'b1;

  typedef struct packed {
    logic                  action;
    logic                  jet_present;
    logic [PHI_BITS-1:0]   jet_phi;
    logic [PT_BITS-1:0]    jet_pt;
    logic                  track_present;
    logic [PHI_BITS-1:0]   track_phi;
    logic [PT_BITS-1:0]    track_pt;
    logic [PHI_BITS-1:0]   particle_phi;
    logic [PT_BITS-1:0]    particle_pt;
    logic                  last_particle;
  } in_item_t;

  typedef struct packed {
    logic                  reference;
    logic [PT_BITS-1:0]    lead_pt;
    logic [COUNT_BITS-1:0] count_min;
    logic [COUNT_BITS-1:0] count_max;
    logic [COUNT_BITS:0]   count_total;
    logic [COUNT_BITS-1:0] count_diff;
    logic [SUM_BITS-1:0]   sum_min;
    logic [SUM_BITS-1:0]   sum_max;
    logic [SUM_BITS:0]     sum_total;
    logic [SUM_BITS-1:0]   sum_diff;
    logic                  last_result;
  } out_item_t;

  typedef struct packed {
    logic [PT_BITS-1:0]              lead_pt;
    logic [1:0][COUNT_BITS-1:0]      cnt;
    logic [1:0][SUM_BITS-1:0]        sum;
  } ref_acc_t;

  typedef ref_acc_t [1:0] snap_t;

  typedef struct packed {
    logic       load;
    logic [1:0] mask;
  } snap_ctl_t;

endpackage

// ===== src/tra_in_stage.sv =====
// Input register of the transverse region accumulator.
// Holds one accepted item until the accumulator takes it; uses tra_pkg.
module tra_in_stage import tra_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     item_vld,
  output in_item_t item,
  input  logic     take
);

  logic     vld_r, vld_nxt;
  in_item_t item_r;

  assign in_stall = vld_r && !take;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && !in_stall) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

endmodule

// ===== src/tra_accum.sv =====
// Reference latch, side classification and saturating side accumulators.
// Hands a snapshot of the updated sums to the result stage; uses tra_pkg.
module tra_accum import tra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_vld,
  input  in_item_t  item,
  output logic      take,
  input  logic      snap_free,
  output snap_ctl_t snap_ctl,
  output snap_t     snap
);

  logic [1:0][PHI_BITS-1:0]   ref_phi_r, ref_phi_nxt;
  logic [1:0][PT_BITS-1:0]    ref_pt_r, ref_pt_nxt;
  logic [1:0]                 ref_valid_r, ref_valid_nxt;
  logic [1:0][1:0][COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0][1:0][SUM_BITS-1:0]   sum_r, sum_nxt;

  logic                  need;
  logic [PHI_BITS-1:0]   diff [2];
  logic [PHI_BITS-1:0]   mag [2];
  logic [PHI_BITS+2:0]   mag6 [2];
  logic [PHI_BITS+2:0]   mag3 [2];
  logic [PHI_BITS+2:0]   turn;
  logic [1:0]            hit;
  logic [SUM_BITS:0]     sum_add [2];

  assign turn = (PHI_BITS+3)'(1) << PHI_BITS;
  assign need = (item.action == ACT_PARTICLE) && item.last_particle && (|ref_valid_r);
  assign take = item_vld && (!need || snap_free);

  always_comb begin
    ref_phi_nxt   = ref_phi_r;
    ref_pt_nxt    = ref_pt_r;
    ref_valid_nxt = ref_valid_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    for (int r = 0; r < 2; r++) begin
      diff[r] = item.particle_phi - ref_phi_r[r];
      mag[r]  = diff[r][PHI_BITS-1] ? (PHI_BITS)'(~diff[r] + 1'b1) : diff[r];
      mag6[r] = (PHI_BITS+3)'(mag[r]) * (PHI_BITS+3)'(6);
      mag3[r] = (PHI_BITS+3)'(mag[r]) * (PHI_BITS+3)'(3);
      hit[r]  = ref_valid_r[r] && (mag6[r] > turn) && (mag3[r] < turn);
      sum_add[r] = {1'b0, sum_r[r][diff[r][PHI_BITS-1]]}
                 + (SUM_BITS+1)'(item.particle_pt);
    end
    if (take) begin
      if (item.action == ACT_HEADER) begin
        ref_valid_nxt = {item.track_present, item.jet_present};
        ref_phi_nxt   = {item.track_phi, item.jet_phi};
        ref_pt_nxt    = {item.track_pt, item.jet_pt};
        cnt_nxt       = '0;
        sum_nxt       = '0;
      end else begin
        for (int r = 0; r < 2; r++) begin
          if (hit[r]) begin
            if (cnt_r[r][diff[r][PHI_BITS-1]] != '1) begin
              cnt_nxt[r][diff[r][PHI_BITS-1]] =
                cnt_r[r][diff[r][PHI_BITS-1]] + 1'b1;
            end
            sum_nxt[r][diff[r][PHI_BITS-1]] =
              sum_add[r][SUM_BITS] ? '1 : sum_add[r][SUM_BITS-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    snap_ctl.load = take && need;
    snap_ctl.mask = ref_valid_r;
    for (int r = 0; r < 2; r++) begin
      snap[r].lead_pt = ref_pt_r[r];
      snap[r].cnt     = cnt_nxt[r];
      snap[r].sum     = sum_nxt[r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_valid_r <= '0;
    end else begin
      ref_valid_r <= ref_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ref_phi_r <= ref_phi_nxt;
    ref_pt_r  <= ref_pt_nxt;
    cnt_r     <= cnt_nxt;
    sum_r     <= sum_nxt;
  end

endmodule

// ===== src/tra_result.sv =====
// Result buffer of the transverse region accumulator.
// Holds one event's snapshot and sends jet then track results; uses tra_pkg.
module tra_result import tra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  snap_ctl_t snap_ctl,
  input  snap_t     snap,
  output logic      snap_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  snap_t      snap_r;
  logic [1:0] pend_r, pend_nxt;
  logic [1:0] sent;
  logic [1:0] pend_left;
  logic       sel;

  logic [COUNT_BITS-1:0] c1, c2, cmin, cmax;
  logic [SUM_BITS-1:0]   s1, s2, smin, smax;

  assign sel       = pend_r[0] ? REF_JET : REF_TRACK;
  assign out_valid = |pend_r;
  assign sent      = (out_valid && !out_stall) ? (sel ? 2'b10 : 2'b01) : 2'b00;
  assign pend_left = pend_r & ~sent;
  assign snap_free = (pend_left == 2'b00);
  assign pend_nxt  = snap_ctl.load ? snap_ctl.mask : pend_left;

  always_comb begin
    c1   = snap_r[sel].cnt[0];
    c2   = snap_r[sel].cnt[1];
    s1   = snap_r[sel].sum[0];
    s2   = snap_r[sel].sum[1];
    cmax = (c2 > c1) ? c2 : c1;
    cmin = (c2 > c1) ? c1 : c2;
    smax = (s2 > s1) ? s2 : s1;
    smin = (s2 > s1) ? s1 : s2;
    out_data.reference   = sel;
    out_data.lead_pt     = snap_r[sel].lead_pt;
    out_data.count_min   = cmin;
    out_data.count_max   = cmax;
    out_data.count_total = {1'b0, cmin} + {1'b0, cmax};
    out_data.count_diff  = cmax - cmin;
    out_data.sum_min     = smin;
    out_data.sum_max     = smax;
    out_data.sum_total   = {1'b0, smin} + {1'b0, smax};
    out_data.sum_diff    = smax - smin;
    out_data.last_result = (sel == REF_TRACK) || !pend_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'b00;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ctl.load) begin
      snap_r <= snap;
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    snap_ctl.load |-> snap_free)
    else $error("snapshot loaded over pending results");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    snap_ctl.load |-> (snap_ctl.mask != 2'b00))
    else $error("snapshot loaded with no reference present");

  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_result) |-> ($countones(pend_r) == 1))
    else $error("final result flagged while another result is pending");

  a_jet_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && sel == REF_JET && pend_r[1] && !snap_ctl.load)
      |=> (pend_r == 2'b10))
    else $error("track result lost after jet transfer");

endmodule

// ===== src/transverse_region_accumulator_unit.sv =====
// Top level of the transverse region accumulator.
// Instantiates tra_in_stage, tra_accum and tra_result; uses tra_pkg.
//
// Takes one item per cycle while in_stall is low: a header latches the
// leading jet and track and clears the side sums, and each particle adds to
// the matching transverse side of every present reference once the input
// register hands it to the accumulator. A last particle copies the updated
// sums into a one-event result buffer, which sends the jet result and then
// the track result, one per cycle while out_stall is low. A further last
// particle waits in the input register while that buffer still holds
// results. Counts saturate at 4095 and sums at 2^32 - 1.
module transverse_region_accumulator_unit import tra_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      item_vld;
  in_item_t  item;
  logic      take;
  logic      snap_free;
  snap_ctl_t snap_ctl;
  snap_t     snap;

  tra_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .item_vld (item_vld),
    .item     (item),
    .take     (take)
  );

  tra_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld),
    .item      (item),
    .take      (take),
    .snap_free (snap_free),
    .snap_ctl  (snap_ctl),
    .snap      (snap)
  );

  tra_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_ctl  (snap_ctl),
    .snap      (snap),
    .snap_free (snap_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench of transverse_region_accumulator_unit: sends event headers and particles
// through the valid/stall channels and checks each result against an in-bench model.
// Depends on tra_pkg and the RTL of the unit; reads no files.
module tb;
  import tra_pkg::*;

  localparam int TURN = 1 << PHI_BITS;
  localparam int HALF_TURN = TURN / 2;
  localparam int SIDE_NONE = 0;
  localparam int SIDE_ONE = 1;
  localparam int SIDE_TWO = 2;
  localparam int SETTLE = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1000;
  localparam int LONG_PARTICLES = 200;

  typedef struct {
    in_item_t  item;
    bit        typed;
    int        n_typed;
    out_item_t result;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic [PHI_BITS-1:0]   lead_phi [2];
  logic [PT_BITS-1:0]    lead_pt [2];
  bit                    lead_on [2];
  logic [COUNT_BITS-1:0] side_cnt [4];
  logic [SUM_BITS-1:0]   side_sum [4];

  out_item_t pending_results [$];
  out_item_t new_results [$];
  stim_row_t script [$];
  int        fail_cnt = 0;
  bit        offering = 1'b0;
  bit        in_steady = 1'b0;
  bit        out_steady = 1'b0;
  bit        hold_req = 1'b0;

  always #2 clk = ~clk;

  transverse_region_accumulator_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic in_item_t hdr(logic jp, logic [PHI_BITS-1:0] jphi,
                                   logic [PT_BITS-1:0] jpt, logic tp,
                                   logic [PHI_BITS-1:0] tphi, logic [PT_BITS-1:0] tpt);
    in_item_t it;
    it = '0;
    it.action = ACT_HEADER;
    it.jet_present = jp;
    it.jet_phi = jphi;
    it.jet_pt = jpt;
    it.track_present = tp;
    it.track_phi = tphi;
    it.track_pt = tpt;
    return it;
  endfunction

  function automatic in_item_t part(logic [PHI_BITS-1:0] phi, logic [PT_BITS-1:0] pt,
                                    logic last);
    in_item_t it;
    it = '0;
    it.action = ACT_PARTICLE;
    it.particle_phi = phi;
    it.particle_pt = pt;
    it.last_particle = last;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic logic [PHI_BITS-1:0] pick_phi(logic [PHI_BITS-1:0] anchor);
    int bounds [6] = '{0, TURN / 6, TURN / 6 + 1, TURN / 3, TURN / 3 + 1, HALF_TURN};
    int off;
    case ($urandom_range(0, 9))
      0, 1, 2: return PHI_BITS'($urandom());
      3, 4, 5: off = $urandom_range(TURN / 6 - 20, TURN / 3 + 20);
      default: off = bounds[$urandom_range(0, 5)];
    endcase
    if ($urandom_range(0, 1) == 1) off = -off;
    return PHI_BITS'(anchor + off);
  endfunction

  function automatic logic [PT_BITS-1:0] pick_pt();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PT_BITS'($urandom());
    endcase
  endfunction

  function automatic int side_of(logic [PHI_BITS-1:0] p, logic [PHI_BITS-1:0] r);
    logic [PHI_BITS-1:0] dv;
    int d;
    int mag;
    int s;
    dv = p - r;
    d = dv;
    if (d == 0 || d == HALF_TURN) return SIDE_NONE;
    if (d < HALF_TURN) begin
      mag = d;
      s = SIDE_ONE;
    end else begin
      mag = TURN - d;
      s = SIDE_TWO;
    end
    if (6 * mag > TURN && 3 * mag < TURN) return s;
    return SIDE_NONE;
  endfunction

  function automatic out_item_t summarize(int r);
    logic [COUNT_BITS-1:0] c1, c2, cmin, cmax;
    logic [SUM_BITS-1:0]   s1, s2, smin, smax;
    logic                  rf;
    out_item_t             res;
    rf = r[0];
    c1 = side_cnt[2 * r];
    c2 = side_cnt[2 * r + 1];
    s1 = side_sum[2 * r];
    s2 = side_sum[2 * r + 1];
    cmax = (c2 > c1) ? c2 : c1;
    cmin = (c2 > c1) ? c1 : c2;
    smax = (s2 > s1) ? s2 : s1;
    smin = (s2 > s1) ? s1 : s2;
    res.reference = rf;
    res.lead_pt = lead_pt[r];
    res.count_min = cmin;
    res.count_max = cmax;
    res.count_total = {1'b0, cmin} + {1'b0, cmax};
    res.count_diff = cmax - cmin;
    res.sum_min = smin;
    res.sum_max = smax;
    res.sum_total = {1'b0, smin} + {1'b0, smax};
    res.sum_diff = smax - smin;
    res.last_result = (rf == REF_TRACK) || !lead_on[REF_TRACK];
    return res;
  endfunction

  task automatic predict_sides(in_item_t it);
    int              sd;
    int              slot;
    logic [SUM_BITS:0] acc;
    new_results.delete();
    if (it.action == ACT_HEADER) begin
      lead_on[REF_JET] = it.jet_present;
      lead_phi[REF_JET] = it.jet_phi;
      lead_pt[REF_JET] = it.jet_pt;
      lead_on[REF_TRACK] = it.track_present;
      lead_phi[REF_TRACK] = it.track_phi;
      lead_pt[REF_TRACK] = it.track_pt;
      for (int k = 0; k < 4; k++) begin
        side_cnt[k] = '0;
        side_sum[k] = '0;
      end
    end else begin
      for (int r = 0; r < 2; r++) begin
        if (lead_on[r]) begin
          sd = side_of(it.particle_phi, lead_phi[r]);
          if (sd != SIDE_NONE) begin
            slot = 2 * r + sd - 1;
            if (side_cnt[slot] != '1) side_cnt[slot] = side_cnt[slot] + 1'b1;
            acc = {1'b0, side_sum[slot]} + (SUM_BITS+1)'(it.particle_pt);
            side_sum[slot] = acc[SUM_BITS] ? '1 : acc[SUM_BITS-1:0];
          end
        end
      end
      if (it.last_particle) begin
        for (int r = 0; r < 2; r++) begin
          if (lead_on[r]) new_results.push_back(summarize(r));
        end
      end
    end
  endtask

  task automatic push_item(in_item_t it, bit typed = 1'b0, int n_typed = 0,
                           out_item_t fixed = '0);
    int gap;
    in_data <= it;
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_sides(it);
    if (typed) begin
      if (n_typed > 0) pending_results.push_back(fixed);
    end else begin
      foreach (new_results[k]) pending_results.push_back(new_results[k]);
    end
    gap = in_steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [SUM_BITS:0] want, logic [SUM_BITS:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_data);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("reference", want.reference, out_data.reference);
        check_field("lead_pt", want.lead_pt, out_data.lead_pt);
        check_field("count_min", want.count_min, out_data.count_min);
        check_field("count_max", want.count_max, out_data.count_max);
        check_field("count_total", want.count_total, out_data.count_total);
        check_field("count_diff", want.count_diff, out_data.count_diff);
        check_field("sum_min", want.sum_min, out_data.sum_min);
        check_field("sum_max", want.sum_max, out_data.sum_max);
        check_field("sum_total", want.sum_total, out_data.sum_total);
        check_field("sum_diff", want.sum_diff, out_data.sum_diff);
        check_field("last_result", want.last_result, out_data.last_result);
      end
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!out_steady) stall_left = gap_len();
      end
    end
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    in_item_t            it;
    in_item_t            head_item;
    logic [PHI_BITS-1:0] anchor;
    int                  made;
    int                  n;
    bit                  broken;
    for (int k = 0; k < 2; k++) begin
      lead_on[k] = 1'b0;
      lead_phi[k] = '0;
      lead_pt[k] = '0;
    end
    for (int k = 0; k < 4; k++) begin
      side_cnt[k] = '0;
      side_sum[k] = '0;
    end

    script.push_back(stim_row_t'{part(16'h4000, '1, 1'b1), 1'b1, 0, '0});
    script.push_back(stim_row_t'{hdr(1'b0, '0, '0, 1'b0, '0, '0), 1'b1, 0, '0});
    script.push_back(stim_row_t'{part(16'h4000, '1, 1'b1), 1'b1, 0, '0});
    script.push_back(stim_row_t'{hdr(1'b1, 16'h0000, '1, 1'b1, 16'hFFFF, '0), 1'b1, 0, '0});
    script.push_back(stim_row_t'{part(16'd10922, '1, 1'b0), 1'b0, 0, '0});
    script.push_back(stim_row_t'{part(16'd10923, '1, 1'b0), 1'b0, 0, '0});
    script.push_back(stim_row_t'{part(16'd21845, 20'd1, 1'b0), 1'b0, 0, '0});
    script.push_back(stim_row_t'{part(16'd21846, 20'd1, 1'b0), 1'b0, 0, '0});
    script.push_back(stim_row_t'{part(16'd32768, '1, 1'b0), 1'b0, 0, '0});
    script.push_back(stim_row_t'{part(16'd0, '1, 1'b0), 1'b0, 0, '0});
    script.push_back(stim_row_t'{part(16'd54613, 20'd2, 1'b0), 1'b0, 0, '0});
    script.push_back(stim_row_t'{part(16'd43691, 20'd3, 1'b0), 1'b0, 0, '0});
    script.push_back(stim_row_t'{part(16'd43690, 20'd0, 1'b1), 1'b0, 0, '0});
    script.push_back(stim_row_t'{part(16'h2AAB, 20'd5, 1'b1), 1'b0, 0, '0});
    script.push_back(stim_row_t'{hdr(1'b1, 16'h1234, 20'd1, 1'b1, 16'h4321, 20'd2),
                                 1'b1, 0, '0});
    script.push_back(stim_row_t'{hdr(1'b0, '0, '0, 1'b1, 16'h8000, 20'd12345), 1'b1, 0, '0});
    script.push_back(stim_row_t'{part(16'hC000, '1, 1'b1), 1'b1, 1,
                                 out_item_t'{REF_TRACK, 20'd12345, 12'd0, 12'd1, 13'd1, 12'd1,
                                             32'd0, 32'h000F_FFFF, 33'h0_000F_FFFF,
                                             32'h000F_FFFF, 1'b1}});
    script.push_back(stim_row_t'{hdr(1'b1, 16'hFFFF, '1, 1'b0, '0, '0), 1'b1, 0, '0});
    script.push_back(stim_row_t'{part(16'h2AAA, '1, 1'b0), 1'b0, 0, '0});
    script.push_back(stim_row_t'{part(16'hD554, '1, 1'b1), 1'b1, 1,
                                 out_item_t'{REF_JET, 20'hFFFFF, 12'd1, 12'd1, 13'd2, 12'd0,
                                             32'h000F_FFFF, 32'h000F_FFFF, 33'h0_001F_FFFE,
                                             32'd0, 1'b1}});
    script.push_back(stim_row_t'{part(16'hFFFF, '1, 1'b1), 1'b0, 0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      push_item(script[i].item, script[i].typed, script[i].n_typed, script[i].result);
    end
    drain();

    // The result port is held off while last particles keep coming, so the
    // unit backs up and stalls its input.
    hold_req = 1'b1;
    in_steady = 1'b1;
    head_item = hdr(1'b1, PHI_BITS'($urandom()), pick_pt(), 1'b1, PHI_BITS'($urandom()),
                    pick_pt());
    push_item(head_item);
    for (int k = 0; k < 40; k++) begin
      push_item(part(pick_phi(head_item.jet_phi), pick_pt(), 1'b1));
    end
    in_steady = 1'b0;
    drain();

    // Long event that fills both sides of both references, with results
    // emitted along the way from the running totals.
    in_steady = 1'b1;
    push_item(hdr(1'b1, 16'h0000, 20'hABCDE, 1'b1, 16'h8000, 20'h12345));
    for (int k = 0; k < LONG_PARTICLES; k++) begin
      push_item(part(k[0] ? 16'hC000 : 16'h4000, '1,
                     (k % 50 == 49) || (k == LONG_PARTICLES - 1)));
    end
    in_steady = 1'b0;
    drain();

    made = 0;
    while (made < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) in_steady = ~in_steady;
      if ($urandom_range(0, 3) == 0) out_steady = ~out_steady;
      it = rand_item();
      it.action = ACT_HEADER;
      case ($urandom_range(0, 9))
        0: {it.jet_present, it.track_present} = 2'b00;
        1, 2: {it.jet_present, it.track_present} = 2'b10;
        3, 4: {it.jet_present, it.track_present} = 2'b01;
        default: {it.jet_present, it.track_present} = 2'b11;
      endcase
      it.jet_pt = pick_pt();
      it.track_pt = pick_pt();
      head_item = it;
      push_item(it);
      made++;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
      broken = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < n; k++) begin
        it = rand_item();
        it.action = ACT_PARTICLE;
        anchor = $urandom_range(0, 1) ? head_item.jet_phi : head_item.track_phi;
        it.particle_phi = pick_phi(anchor);
        it.particle_pt = pick_pt();
        if (!broken) it.last_particle = (k == n - 1);
        push_item(it);
        made++;
      end
      if ($urandom_range(0, 19) == 0) drain();
    end
    in_steady = 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);

    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
